>>> rtl/bank_switch_irq_mapper_assert.svh
// assertion macros shared by the mapper rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef BANK_SWITCH_IRQ_MAPPER_ASSERT_SVH
`define BANK_SWITCH_IRQ_MAPPER_ASSERT_SVH

// checked on every clock edge outside reset
`define BSIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BSIM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/bsim_pkg.sv
// types, codes and register addresses of the bank switch irq mapper
// no dependencies
package bsim_pkg;

    localparam int unsigned CountW = 18;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CYCLE = 2'd1,
        ACT_LINE  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PRG    = 2'd1,
        KIND_CHR    = 2'd2,
        KIND_MIRROR = 2'd3
    } t_kind;

    // counter operation carried from the decoder to the irq unit
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CTL,
        OP_RELOAD,
        OP_LATCH_HI,
        OP_LATCH_LO,
        OP_ALT_LOAD,
        OP_ALT_ENABLE,
        OP_CYCLE_TICK,
        OP_LINE_TICK
    } t_op;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] slot;
        logic [7:0] bank;
        logic       mirror;
        t_op        op;
    } t_dec;

    localparam logic [15:0] ADDR_PRG0     = 16'h8000;
    localparam logic [15:0] ADDR_PRG1     = 16'hA000;
    localparam logic [15:0] ADDR_PRG2     = 16'hC000;
    localparam logic [15:0] ADDR_CHR      = 16'hB000;
    localparam logic [15:0] ADDR_CHR_MASK = 16'hFFF8;
    localparam logic [15:0] ADDR_MIR0     = 16'h9000;
    localparam logic [15:0] ADDR_MIR1     = 16'h9001;
    localparam logic [15:0] ADDR_IRQ_CTL  = 16'h9003;
    localparam logic [15:0] ADDR_IRQ_LOAD = 16'h9004;
    localparam logic [15:0] ADDR_IRQ_HI   = 16'h9005;
    localparam logic [15:0] ADDR_IRQ_LO   = 16'h9006;

    localparam logic [2:0] SLOT_PRG0 = 3'd4;
    localparam logic [2:0] SLOT_PRG1 = 3'd5;
    localparam logic [2:0] SLOT_PRG2 = 3'd6;

endpackage

>>> rtl/bsim_in_if.sv
// input event channel of the mapper
// depends on nothing
interface bsim_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  value;
    logic [7:0]  cycle_count;

    modport source (output valid, action, address, value, cycle_count, input ready);
    modport sink   (input valid, action, address, value, cycle_count, output ready);
endinterface

>>> rtl/bsim_out_if.sv
// result channel of the mapper
// depends on nothing
interface bsim_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] update_kind;
    logic [2:0] slot;
    logic [7:0] bank_number;
    logic       mirror_select;
    logic       irq_level;

    modport source (output valid, update_kind, slot, bank_number, mirror_select, irq_level,
                    input ready);
    modport sink   (input valid, update_kind, slot, bank_number, mirror_select, irq_level,
                    output ready);
endinterface

>>> rtl/bsim_cfg_if.sv
// configuration write channel of the mapper, carries the mode bit
// depends on nothing
interface bsim_cfg_if;
    logic valid;
    logic ready;
    logic alt_mode;

    modport source (output valid, alt_mode, input ready);
    modport sink   (input valid, alt_mode, output ready);
endinterface

>>> rtl/bsim_decode.sv
// decodes one event into a bank/mirroring update and a counter operation
// depends on bsim_pkg
module bsim_decode (
    input  logic              i_alt_mode,
    input  logic [1:0]        i_action,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_value,
    output bsim_pkg::t_dec    o_dec
);

    always_comb begin
        o_dec      = '0;
        o_dec.kind = bsim_pkg::KIND_NONE;
        o_dec.op   = bsim_pkg::OP_NONE;
        unique case (bsim_pkg::t_action'(i_action))
            bsim_pkg::ACT_WRITE: begin
                if (i_address == bsim_pkg::ADDR_PRG0) begin
                    o_dec.kind = bsim_pkg::KIND_PRG;
                    o_dec.slot = bsim_pkg::SLOT_PRG0;
                    o_dec.bank = i_value;
                end else if (i_address == bsim_pkg::ADDR_PRG1) begin
                    o_dec.kind = bsim_pkg::KIND_PRG;
                    o_dec.slot = bsim_pkg::SLOT_PRG1;
                    o_dec.bank = i_value;
                end else if (i_address == bsim_pkg::ADDR_PRG2) begin
                    o_dec.kind = bsim_pkg::KIND_PRG;
                    o_dec.slot = bsim_pkg::SLOT_PRG2;
                    o_dec.bank = i_value;
                end else if ((i_address & bsim_pkg::ADDR_CHR_MASK) == bsim_pkg::ADDR_CHR) begin
                    o_dec.kind = bsim_pkg::KIND_CHR;
                    o_dec.slot = i_address[2:0];
                    o_dec.bank = i_value;
                end else if (i_address == bsim_pkg::ADDR_MIR0 && !i_alt_mode) begin
                    o_dec.kind   = bsim_pkg::KIND_MIRROR;
                    o_dec.mirror = ~i_value[6];
                end else if (i_address == bsim_pkg::ADDR_MIR1 && i_alt_mode) begin
                    o_dec.kind   = bsim_pkg::KIND_MIRROR;
                    o_dec.mirror = i_value[7];
                end else if (i_address == bsim_pkg::ADDR_IRQ_CTL && !i_alt_mode) begin
                    o_dec.op = bsim_pkg::OP_CTL;
                end else if (i_address == bsim_pkg::ADDR_IRQ_LOAD && !i_alt_mode) begin
                    o_dec.op = bsim_pkg::OP_RELOAD;
                end else if (i_address == bsim_pkg::ADDR_IRQ_HI) begin
                    o_dec.op = i_alt_mode ? bsim_pkg::OP_ALT_LOAD : bsim_pkg::OP_LATCH_HI;
                end else if (i_address == bsim_pkg::ADDR_IRQ_LO) begin
                    o_dec.op = i_alt_mode ? bsim_pkg::OP_ALT_ENABLE : bsim_pkg::OP_LATCH_LO;
                end
            end
            bsim_pkg::ACT_CYCLE: begin
                if (!i_alt_mode) o_dec.op = bsim_pkg::OP_CYCLE_TICK;
            end
            bsim_pkg::ACT_LINE: begin
                if (i_alt_mode) o_dec.op = bsim_pkg::OP_LINE_TICK;
            end
            default: begin
                o_dec.op = bsim_pkg::OP_NONE;
            end
        endcase
    end

endmodule

>>> rtl/bsim_irq.sv
// interrupt counter: enable, reload latch, 18-bit counter and irq line
// depends on bsim_pkg and bank_switch_irq_mapper_assert.svh
`include "bank_switch_irq_mapper_assert.svh"

module bsim_irq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  bsim_pkg::t_op                 i_op,
    input  logic [7:0]                    i_value,
    input  logic [7:0]                    i_cycles,
    output logic                          o_irq_next
);

    logic                         r_irq_enabled, n_irq_enabled;
    logic [bsim_pkg::CountW-1:0]  r_count, n_count;
    logic [15:0]                  r_latch, n_latch;
    logic                         r_irq_line, n_irq_line;
    logic                         w_count_le0;

    // signed count <= 0
    assign w_count_le0 = r_count[bsim_pkg::CountW-1] || (r_count == '0);

    always_comb begin
        n_irq_enabled = r_irq_enabled;
        n_count       = r_count;
        n_latch       = r_latch;
        n_irq_line    = r_irq_line;
        case (i_op)
            bsim_pkg::OP_CTL: begin
                n_irq_enabled = i_value[7];
                n_irq_line    = 1'b0;
            end
            bsim_pkg::OP_RELOAD:    n_count = {{(bsim_pkg::CountW-16){1'b0}}, r_latch};
            bsim_pkg::OP_LATCH_HI:  n_latch = {i_value, r_latch[7:0]};
            bsim_pkg::OP_LATCH_LO:  n_latch = {r_latch[15:8], i_value};
            bsim_pkg::OP_ALT_LOAD: begin
                n_count       = {{(bsim_pkg::CountW-8){1'b0}}, i_value[6:0], 1'b0};
                n_irq_enabled = |i_value;
                n_irq_line    = 1'b0;
            end
            bsim_pkg::OP_ALT_ENABLE: n_irq_enabled = 1'b1;
            bsim_pkg::OP_CYCLE_TICK: begin
                if (r_irq_enabled) begin
                    if (w_count_le0) n_irq_line = 1'b1;
                    else n_count = r_count - {{(bsim_pkg::CountW-8){1'b0}}, i_cycles};
                end
            end
            bsim_pkg::OP_LINE_TICK: begin
                if (r_irq_enabled) begin
                    if (r_count == '0) n_irq_line = 1'b1;
                    else n_count = r_count - {{(bsim_pkg::CountW-1){1'b0}}, 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_irq_next = n_irq_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enabled <= 1'b0;
            r_count       <= '0;
            r_latch       <= '0;
            r_irq_line    <= 1'b0;
        end else if (i_fire) begin
            r_irq_enabled <= n_irq_enabled;
            r_count       <= n_count;
            r_latch       <= n_latch;
            r_irq_line    <= n_irq_line;
        end
    end

    `BSIM_ASSERT(a_ctl_clears_line, i_fire && i_op == bsim_pkg::OP_CTL |=> !r_irq_line, "irq line not cleared by control write")
    `BSIM_ASSERT(a_line_sticky, r_irq_line && !(i_fire && (i_op == bsim_pkg::OP_CTL || i_op == bsim_pkg::OP_ALT_LOAD)) |=> r_irq_line, "irq line dropped without a clearing write")
    `BSIM_ASSERT(a_idle_when_disabled, i_fire && !r_irq_enabled && (i_op == bsim_pkg::OP_CYCLE_TICK || i_op == bsim_pkg::OP_LINE_TICK) |=> $stable(r_count) && $stable(r_irq_line), "disabled counter changed on a tick")

endmodule

>>> rtl/bank_switch_irq_mapper.sv
// top level of the bank switch irq mapper: input register, decode, counter, result register
// depends on bsim_pkg, the channel interfaces, bsim_decode, bsim_irq and the assert header
//
// usage:
//   i_in carries one event per transaction: a cpu register write, a cpu cycle tick
//   (with its cycle count) or a scanline tick. every accepted event gives exactly one
//   result transaction on o_out with the bank/mirroring update and the irq line level.
//   i_cfg writes the mode bit (0 cycle counter with latch, 1 scanline counter); it is
//   always ready and should only be written while no event is in flight.
// timing:
//   an accepted event is held in the input register and moves on to the output register
//   when that is free; o_out.valid then rises and the result can be taken. one event
//   per cycle is taken sustained while o_out.ready stays high; the counter update is a
//   single 18-bit subtract or load done between the two registers.
// reset:
//   synchronous active low; empties both registers, clears mode, enable, counter,
//   reload latch and irq line.
// stalls:
//   while o_out.ready is low the result holds and the input register keeps one more
//   event; i_in.ready drops only when both are full.
`include "bank_switch_irq_mapper_assert.svh"

module bank_switch_irq_mapper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsim_in_if.sink       i_in,
    bsim_cfg_if.sink      i_cfg,
    bsim_out_if.source    o_out
);

    logic                r_alt_mode;
    logic                r_in_valid;
    logic [1:0]          r_in_action;
    logic [15:0]         r_in_address;
    logic [7:0]          r_in_value;
    logic [7:0]          r_in_cycles;
    logic                r_out_valid;
    bsim_pkg::t_kind     r_kind;
    logic [2:0]          r_slot;
    logic [7:0]          r_bank;
    logic                r_mirror;
    logic                r_irq;
    logic                w_out_free;
    logic                w_advance;
    logic                w_in_take;
    logic                w_irq_next;
    bsim_pkg::t_dec      w_dec;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    bsim_decode u_decode (
        .i_alt_mode (r_alt_mode),
        .i_action   (r_in_action),
        .i_address  (r_in_address),
        .i_value    (r_in_value),
        .o_dec      (w_dec)
    );

    bsim_irq u_irq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_op       (w_dec.op),
        .i_value    (r_in_value),
        .i_cycles   (r_in_cycles),
        .o_irq_next (w_irq_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_mode  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_alt_mode <= i_cfg.alt_mode;
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (w_out_free) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action  <= i_in.action;
            r_in_address <= i_in.address;
            r_in_value   <= i_in.value;
            r_in_cycles  <= i_in.cycle_count;
        end
        if (w_advance) begin
            r_kind   <= w_dec.kind;
            r_slot   <= w_dec.slot;
            r_bank   <= w_dec.bank;
            r_mirror <= w_dec.mirror;
            r_irq    <= w_irq_next;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.update_kind   = r_kind;
    assign o_out.slot          = r_slot;
    assign o_out.bank_number   = r_bank;
    assign o_out.mirror_select = r_mirror;
    assign o_out.irq_level     = r_irq;

    `BSIM_ASSERT(a_in_held, r_in_valid && !w_out_free |=> r_in_valid && $stable(r_in_address), "pending event lost while output stalled")
    `BSIM_ASSERT(a_none_is_zero, r_out_valid && r_kind == bsim_pkg::KIND_NONE |-> r_slot == 3'd0 && r_bank == 8'd0 && !r_mirror, "empty update carries nonzero fields")
    `BSIM_ASSERT(a_prg_slot, r_out_valid && r_kind == bsim_pkg::KIND_PRG |-> r_slot == bsim_pkg::SLOT_PRG0 || r_slot == bsim_pkg::SLOT_PRG1 || r_slot == bsim_pkg::SLOT_PRG2, "program update to a bad slot")

endmodule

>>> tb/tb_bank_switch_irq_mapper.sv
// self-checking testbench of bank_switch_irq_mapper: directed and random cpu writes and ticks
// depends on bsim_pkg, the three channel interfaces and the mapper rtl
// a tracker class predicts each result and compares it with the one seen on o_out

module tb_bank_switch_irq_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import bsim_pkg::*;

    // expected bank/mirroring updates and irq line, predicted from accepted events
    class bank_irq_tracker;
        typedef struct packed {
            t_kind      kind;
            logic [2:0] slot;
            logic [7:0] bank;
            logic       mirror;
            logic       irq;
        } t_update;

        bit              scan_mode;
        bit              counting;
        logic [17:0]     count;
        logic [15:0]     latch;
        bit              line_up;
        t_update         expected_updates[$];
        int              errors;

        function void clear();
            scan_mode = 1'b0;
            counting  = 1'b0;
            count     = '0;
            latch     = '0;
            line_up   = 1'b0;
            expected_updates.delete();
            errors    = 0;
        endfunction

        function void note_event(logic [1:0] act, logic [15:0] addr, logic [7:0] val,
                                 logic [7:0] cyc);
            t_update upd;
            upd = '0;
            upd.kind = KIND_NONE;
            case (t_action'(act))
                ACT_WRITE: begin
                    if (addr == ADDR_PRG0 || addr == ADDR_PRG1 || addr == ADDR_PRG2) begin
                        upd.kind = KIND_PRG;
                        upd.slot = (addr == ADDR_PRG0) ? SLOT_PRG0 :
                                   (addr == ADDR_PRG1) ? SLOT_PRG1 : SLOT_PRG2;
                        upd.bank = val;
                    end else if ((addr & ADDR_CHR_MASK) == ADDR_CHR) begin
                        upd.kind = KIND_CHR;
                        upd.slot = addr[2:0];
                        upd.bank = val;
                    end else if (addr == ADDR_MIR0 && !scan_mode) begin
                        upd.kind   = KIND_MIRROR;
                        upd.mirror = ~val[6];
                    end else if (addr == ADDR_MIR1 && scan_mode) begin
                        upd.kind   = KIND_MIRROR;
                        upd.mirror = val[7];
                    end else if (addr == ADDR_IRQ_CTL && !scan_mode) begin
                        counting = val[7];
                        line_up  = 1'b0;
                    end else if (addr == ADDR_IRQ_LOAD && !scan_mode) begin
                        count = {2'b00, latch};
                    end else if (addr == ADDR_IRQ_HI) begin
                        if (scan_mode) begin
                            count    = {10'd0, val[6:0], 1'b0};
                            counting = (val != 8'd0);
                            line_up  = 1'b0;
                        end else begin
                            latch[15:8] = val;
                        end
                    end else if (addr == ADDR_IRQ_LO) begin
                        if (scan_mode) counting = 1'b1;
                        else latch[7:0] = val;
                    end
                end
                ACT_CYCLE: begin
                    if (!scan_mode && counting) begin
                        if ($signed(count) <= 0) line_up = 1'b1;
                        else count = count - {10'd0, cyc};
                    end
                end
                ACT_LINE: begin
                    if (scan_mode && counting) begin
                        if (count == '0) line_up = 1'b1;
                        else count = count - 18'd1;
                    end
                end
                default: ;
            endcase
            upd.irq = line_up;
            expected_updates.push_back(upd);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_update(logic [1:0] kind, logic [2:0] slot, logic [7:0] bank,
                                   logic mirror, logic irq);
            t_update exp_u;
            if (expected_updates.size() == 0) begin
                $error("result transaction with no event waiting");
                errors++;
                return;
            end
            exp_u = expected_updates.pop_front();
            compare_field("update_kind", exp_u.kind, kind);
            compare_field("slot", exp_u.slot, slot);
            compare_field("bank_number", exp_u.bank, bank);
            compare_field("mirror_select", exp_u.mirror, mirror);
            compare_field("irq_level", exp_u.irq, irq);
        endfunction

        function int waiting();
            return expected_updates.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsim_in_if  in_ch();
    bsim_out_if out_ch();
    bsim_cfg_if cfg_ch();

    bank_irq_tracker tracker = new();

    int idle_pct;
    int stall_pct;
    int sent;
    bit cur_mode;

    bank_switch_irq_mapper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // outputs of the dut are sampled here before the edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                tracker.check_update(out_ch.update_kind, out_ch.slot, out_ch.bank_number,
                                     out_ch.mirror_select, out_ch.irq_level);
            if (in_ch.valid && in_ch.ready)
                tracker.note_event(in_ch.action, in_ch.address, in_ch.value,
                                   in_ch.cycle_count);
        end
    end

    task automatic send(input t_action act, input logic [15:0] addr, input logic [7:0] val,
                        input logic [7:0] cyc);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.address     <= addr;
        in_ch.value       <= val;
        in_ch.cycle_count <= cyc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic wr(input logic [15:0] addr, input logic [7:0] val);
        send(ACT_WRITE, addr, val, 8'($urandom));
    endtask

    task automatic tick(input t_action act, input logic [7:0] cyc);
        send(act, 16'($urandom), 8'($urandom), cyc);
    endtask

    // hold the sender off until every transaction in flight has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.waiting() != 0) @(posedge i_clk);
    endtask

    task automatic set_mode(input bit m);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.alt_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid       <= 1'b0;
        tracker.scan_mode  = m;
        cur_mode           = m;
    endtask

    // program the counter, arm it and let it run for a while
    task automatic counter_run();
        int n;
        n = $urandom_range(1, 12);
        if (!cur_mode) begin
            wr(ADDR_IRQ_HI, ($urandom_range(0, 99) < 75) ? 8'd0 : 8'($urandom));
            wr(ADDR_IRQ_LO, 8'($urandom));
            if ($urandom_range(0, 9) != 0) wr(ADDR_IRQ_LOAD, 8'($urandom));
            wr(ADDR_IRQ_CTL, {($urandom_range(0, 9) != 0), 7'($urandom)});
        end else begin
            wr(ADDR_IRQ_HI, ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 6))
                                                         : 8'($urandom));
            if ($urandom_range(0, 3) == 0) wr(ADDR_IRQ_LO, 8'($urandom));
        end
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                wr(($urandom_range(0, 1) != 0) ? ADDR_PRG1 : (ADDR_CHR | 16'($urandom_range(0, 7))),
                   8'($urandom));
            else
                tick(cur_mode ? ACT_LINE : ACT_CYCLE, 8'($urandom));
        end
    endtask

    task automatic noise_item();
        logic [15:0] addr;
        case ($urandom_range(0, 11))
            0: addr = ADDR_PRG0;
            1: addr = ADDR_PRG1;
            2: addr = ADDR_PRG2;
            3: addr = ADDR_CHR | 16'($urandom_range(0, 7));
            4: addr = ADDR_CHR + 16'd8;
            5: addr = ADDR_MIR0;
            6: addr = ADDR_MIR1;
            7: addr = ADDR_IRQ_CTL;
            8: addr = ADDR_IRQ_LOAD;
            9: addr = ADDR_IRQ_HI;
            10: addr = ADDR_IRQ_LO;
            default: addr = 16'($urandom);
        endcase
        if ($urandom_range(0, 1) != 0) send(ACT_WRITE, addr, 8'($urandom), 8'($urandom));
        else send(t_action'($urandom_range(0, 3)), addr, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        int idle_tab[6]  = '{0, 65, 0, 65, 0, 26};
        int stall_tab[6] = '{0, 0, 65, 65, 0, 26};
        bit mode_tab[6]  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        int target;

        tracker.clear();
        idle_pct           = 0;
        stall_pct          = 0;
        sent               = 0;
        cur_mode           = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_WRITE;
        in_ch.address      = '0;
        in_ch.value        = '0;
        in_ch.cycle_count  = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.alt_mode    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cycle counter mode: banks, mirroring, latch and expiry through a negative count
        set_mode(1'b0);
        wr(ADDR_PRG0, 8'h00);
        wr(ADDR_PRG1, 8'hFF);
        wr(ADDR_PRG2, 8'hA5);
        wr(ADDR_CHR, 8'h00);
        wr(ADDR_CHR | 16'd7, 8'hFF);
        wr(ADDR_MIR0, 8'h40);
        wr(ADDR_MIR0, 8'hBF);
        wr(ADDR_MIR1, 8'h80);
        wr(ADDR_IRQ_HI, 8'h00);
        wr(ADDR_IRQ_LO, 8'h03);
        wr(ADDR_IRQ_LOAD, 8'h00);
        wr(ADDR_IRQ_CTL, 8'h80);
        tick(ACT_CYCLE, 8'd2);
        tick(ACT_CYCLE, 8'd255);
        tick(ACT_CYCLE, 8'd0);
        tick(ACT_LINE, 8'd1);
        send(ACT_NONE, 16'hFFFF, 8'hFF, 8'hFF);
        wr(16'hFFFF, 8'hFF);

        // scanline mode: the negative count carries over and counts down on a line tick
        drain();
        set_mode(1'b1);
        tick(ACT_LINE, 8'd0);
        wr(ADDR_MIR1, 8'h80);
        wr(ADDR_IRQ_CTL, 8'h00);
        wr(ADDR_IRQ_HI, 8'h01);
        tick(ACT_LINE, 8'd0);
        tick(ACT_LINE, 8'd0);
        tick(ACT_LINE, 8'd0);
        wr(ADDR_IRQ_HI, 8'h00);
        wr(ADDR_IRQ_LO, 8'h00);
        tick(ACT_LINE, 8'd0);
        tick(ACT_CYCLE, 8'd7);

        for (int p = 0; p < 6; p++) begin
            drain();
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            set_mode(mode_tab[p]);
            target = sent + 75;
            while (sent < target) begin
                if ($urandom_range(0, 99) < 70) counter_run();
                else noise_item();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.waiting() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
